// ===== rtl/core/npf_pkg.sv =====
// Shared types and constants for the nearest point path follower.
// Depends on nothing.
`default_nettype none
package npf_pkg;
    localparam int unsigned CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] CFG_GAIN = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_TOL  = 1'b1;

    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [23:0] ANG_MAX     = 24'sd6588313;

    // Rounded atan(2^-i) in radians * 2^30.
    function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
        logic signed [35:0] v;
        case (i)
            5'd0: v = 36'sd843314857;  5'd1: v = 36'sd497837829;
            5'd2: v = 36'sd263043837;  5'd3: v = 36'sd133525159;
            5'd4: v = 36'sd67021687;   5'd5: v = 36'sd33543516;
            5'd6: v = 36'sd16775851;   5'd7: v = 36'sd8388437;
            5'd8: v = 36'sd4194283;    5'd9: v = 36'sd2097149;
            5'd31: v = 36'sd0;
            default: v = 36'sd1 <<< (5'd30 - i);
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/nearest_point_path_follower.sv =====
// Nearest point path follower: path store, nearest scan, CORDIC, sqrt, scaling.
// Depends on npf_pkg and npf_ram.
`default_nettype none
// Usage:
//   Items enter on start while busy is low. mode 0 loads a path point into
//   the path memories; mode 1 is a control tick carrying the robot pose.
//   A load does not make the block busy and the next item may follow at once. A tick
//   with a stored path scans every stored point through one memory read port
//   (one point a cycle, then the square and compare registers drain), runs the
//   heading and yaw CORDIC vectorings side by side one step a cycle, a 34 step
//   restoring square root and a scaling step (S_MUL); busy is high throughout.
//   A tick with an empty path does not make the block busy and gives nothing.
//   Results appear on o_valid for one cycle each: one command, or at goal a
//   command followed by a zero command with o_path_done set. o_last_result
//   marks the final result. The receiver cannot stall the block.
//   Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index, i_cfg_data;
//   write only while idle. Reset empties the path and sets gain to 1.0 and
//   tolerance to 3277. The path memories need no clearing after reset.
module nearest_point_path_follower #(
    parameter int unsigned PATH_DEPTH   = 1024,
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       i_mode,
    input  wire logic signed [31:0]         i_pos_x,
    input  wire logic signed [31:0]         i_pos_y,
    input  wire logic                       i_last_point,
    input  wire logic                       i_pose_valid,
    input  wire logic signed [15:0]         i_quat_x,
    input  wire logic signed [15:0]         i_quat_y,
    input  wire logic signed [15:0]         i_quat_z,
    input  wire logic signed [15:0]         i_quat_w,
    output logic                            o_valid,
    output logic [31:0]                     o_linear_cmd,
    output logic signed [23:0]              o_angular_cmd,
    output logic                            o_path_done,
    output logic                            o_last_result,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [npf_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire logic [31:0]                i_cfg_data
);
    import npf_pkg::*;

    localparam int unsigned AW   = $clog2(PATH_DEPTH);
    localparam int unsigned LW   = $clog2(PATH_DEPTH + 1);
    localparam int unsigned NST  = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int unsigned SW   = $clog2(NST + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_TAIL, S_RD, S_PREP, S_COR, S_SQRT, S_MUL, S_OUT1, S_OUT2
    } t_state;

    t_state r_state;
    logic [15:0] r_gain;
    logic [31:0] r_tol;
    logic [LW-1:0] r_len;
    logic r_new_path;

    // Tick working registers.
    logic signed [31:0] r_rx, r_ry;
    logic signed [31:0] r_qx, r_qy, r_qz, r_qw;
    logic [LW-1:0] r_idx;      // issued read address
    logic [LW-1:0] r_cmp_idx;  // index of data now on the read port
    logic r_cmp_v;
    logic [AW-1:0] r_best;
    logic [65:0] r_best_d;
    logic r_have_best;

    // Memory ports.
    logic mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0] rd_x, rd_y;

    npf_ram #(.WIDTH(32), .DEPTH(PATH_DEPTH)) u_ram_x (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_addr), .i_wdata(i_pos_x), .o_rdata(rd_x)
    );
    npf_ram #(.WIDTH(32), .DEPTH(PATH_DEPTH)) u_ram_y (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_addr), .i_wdata(i_pos_y), .o_rdata(rd_y)
    );

    logic accept;
    assign accept = start && !busy;
    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    // Load write address after a possible path restart.
    logic [LW-1:0] load_len;
    assign load_len = r_new_path ? '0 : r_len;
    assign mem_we = accept && !i_mode && (load_len < LW'(PATH_DEPTH));
    always_comb begin
        if (accept) begin
            mem_addr = load_len[AW-1:0];
        end else if (r_state == S_RD) begin
            mem_addr = r_best;
        end else begin
            mem_addr = r_idx[AW-1:0];
        end
    end

    // Squared distance of the point on the read port.
    logic signed [32:0] sc_dx, sc_dy;
    logic [32:0] sc_ax, sc_ay;
    logic [65:0] sc_d;
    assign sc_dx = $signed({rd_x[31], rd_x}) - $signed({r_rx[31], r_rx});
    assign sc_dy = $signed({rd_y[31], rd_y}) - $signed({r_ry[31], r_ry});
    assign sc_ax = sc_dx[32] ? 33'(-sc_dx) : 33'(sc_dx);
    assign sc_ay = sc_dy[32] ? 33'(-sc_dy) : 33'(sc_dy);
    // Squares registered before the compare.
    logic [65:0] r_sq_x, r_sq_y;
    logic [LW-1:0] r_sq_idx;
    logic r_sq_v;
    assign sc_d = r_sq_x + r_sq_y;

    // CORDIC units (heading and yaw), one step a cycle, shared step counter.
    logic signed [35:0] r_hx, r_hy, r_hz, r_yx, r_yy, r_yz;
    logic r_h_zero, r_y_zero;
    logic [SW-1:0] r_step;
    logic signed [35:0] err_raw, err_w;
    logic signed [51:0] ang_prod;
    logic signed [26:0] ang_sh;

    // Square root.
    logic [33:0] r_root;
    logic [5:0] r_bit;
    logic [33:0] sq_t;
    logic [67:0] sq_tt;
    assign sq_t  = r_root | (34'd1 << r_bit);
    assign sq_tt = 68'(sq_t) * 68'(sq_t);

    logic [49:0] r_lin_prod;
    logic signed [51:0] r_ang_prod;
    logic r_done;
    logic [31:0] lin_sat;
    logic signed [23:0] ang_sat;

    // Yaw vector terms (Q1.14 products), computed in prep.
    logic signed [33:0] yv_y, yv_x;
    assign yv_y = 34'(2 * (34'(r_qw) * 34'(r_qz) + 34'(r_qx) * 34'(r_qy)));
    assign yv_x = 34'(34'(r_qw) * 34'(r_qw) + 34'(r_qx) * 34'(r_qx)
                  - 34'(r_qy) * 34'(r_qy) - 34'(r_qz) * 34'(r_qz));

    // Initial quadrant turn for a vector.
    function automatic logic [107:0] pre_turn(input logic signed [35:0] y,
                                              input logic signed [35:0] x);
        logic signed [35:0] nx, ny, nz;
        nx = x; ny = y; nz = '0;
        if (x < 0) begin
            if (y >= 0) begin
                nx = y; ny = -x; nz = HALF_PI_Q30;
            end else begin
                nx = -y; ny = x; nz = -HALF_PI_Q30;
            end
        end
        return {nx, ny, nz};
    endfunction

    // One CORDIC vectoring step.
    function automatic logic [107:0] cstep(input logic signed [35:0] x,
                                           input logic signed [35:0] y,
                                           input logic signed [35:0] z,
                                           input logic [4:0] i);
        logic signed [35:0] sx, sy;
        sx = x >>> i; sy = y >>> i;
        if (y > 0) begin
            return {x + sy, y - sx, z + atan_q30(i)};
        end
        return {x - sy, y + sx, z - atan_q30(i)};
    endfunction

    logic [107:0] h_pre, y_pre, h_nx, y_nx;
    logic signed [32:0] b_dx, b_dy;
    assign b_dx = $signed({rd_x[31], rd_x}) - $signed({r_rx[31], r_rx});
    assign b_dy = $signed({rd_y[31], rd_y}) - $signed({r_ry[31], r_ry});
    assign h_pre = pre_turn(36'(b_dy), 36'(b_dx));
    assign y_pre = pre_turn(36'(yv_y), 36'(yv_x));
    assign h_nx = cstep(r_hx, r_hy, r_hz, 5'(r_step));
    assign y_nx = cstep(r_yx, r_yy, r_yz, 5'(r_step));

    // Wrap the angle error once into plus or minus pi; a zero vector has angle zero.
    always_comb begin
        err_raw = (r_h_zero ? 36'sd0 : r_hz) - (r_y_zero ? 36'sd0 : r_yz);
        err_w = err_raw;
        if (err_raw > PI_Q30) err_w = err_raw - TWO_PI_Q30;
        if (err_raw < -PI_Q30) err_w = err_raw + TWO_PI_Q30;
        ang_prod = 52'($signed({1'b0, r_gain})) * 52'(err_w);
    end

    // Saturate the scaled commands.
    always_comb begin
        lin_sat = (|r_lin_prod[49:40]) ? 32'hFFFF_FFFF : r_lin_prod[39:8];
        ang_sh = 27'(r_ang_prod >>> 25);
        if (ang_sh > 27'(ANG_MAX)) ang_sat = ANG_MAX;
        else if (ang_sh < -27'(ANG_MAX)) ang_sat = -ANG_MAX;
        else ang_sat = ang_sh[23:0];
    end

    // Control and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gain <= 16'd256;
            r_tol <= 32'd3277;
            r_len <= '0;
            r_new_path <= 1'b1;
            o_valid <= 1'b0;
            r_cmp_v <= 1'b0;
            r_sq_v <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        if (i_cfg_index == CFG_GAIN) r_gain <= i_cfg_data[15:0];
                        else if (i_cfg_index == CFG_TOL) r_tol <= i_cfg_data;
                    end
                    if (accept) begin
                        if (!i_mode) begin
                            r_len <= (load_len < LW'(PATH_DEPTH)) ? load_len + 1'b1
                                                                 : load_len;
                            r_new_path <= i_last_point;
                        end else if (r_len != '0) begin
                            r_rx <= i_pose_valid ? i_pos_x : '0;
                            r_ry <= i_pose_valid ? i_pos_y : '0;
                            r_qx <= i_pose_valid ? 32'(i_quat_x) : '0;
                            r_qy <= i_pose_valid ? 32'(i_quat_y) : '0;
                            r_qz <= i_pose_valid ? 32'(i_quat_z) : '0;
                            r_qw <= i_pose_valid ? 32'(i_quat_w) : 32'sd16384;
                            r_idx <= '0;
                            r_cmp_v <= 1'b0;
                            r_sq_v <= 1'b0;
                            r_have_best <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN, S_TAIL: begin
                    // Issue reads, square, then compare; strict less keeps the first.
                    r_cmp_v <= (r_state == S_SCAN);
                    r_cmp_idx <= r_idx;
                    if (r_state == S_SCAN) begin
                        r_idx <= r_idx + 1'b1;
                        if (r_idx + 1'b1 == r_len) r_state <= S_TAIL;
                    end
                    r_sq_v <= r_cmp_v;
                    r_sq_idx <= r_cmp_idx;
                    r_sq_x <= 66'(sc_ax) * 66'(sc_ax);
                    r_sq_y <= 66'(sc_ay) * 66'(sc_ay);
                    if (r_sq_v && (!r_have_best || sc_d < r_best_d)) begin
                        r_best_d <= sc_d;
                        r_best <= r_sq_idx[AW-1:0];
                        r_have_best <= 1'b1;
                    end
                    if (r_state == S_TAIL && !r_cmp_v && !r_sq_v) r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    {r_hx, r_hy, r_hz} <= h_pre;
                    {r_yx, r_yy, r_yz} <= y_pre;
                    r_h_zero <= (b_dx == '0) && (b_dy == '0);
                    r_y_zero <= (yv_x == '0) && (yv_y == '0);
                    r_step <= '0;
                    r_state <= S_COR;
                end
                S_COR: begin
                    if (r_step == SW'(NST)) begin
                        r_root <= '0;
                        r_bit <= 6'd33;
                        r_state <= S_SQRT;
                    end else begin
                        {r_hx, r_hy, r_hz} <= h_nx;
                        {r_yx, r_yy, r_yz} <= y_nx;
                        r_step <= r_step + 1'b1;
                    end
                end
                S_SQRT: begin
                    if (68'(r_best_d) >= sq_tt) r_root <= sq_t;
                    if (r_bit == 6'd0) r_state <= S_MUL;
                    else r_bit <= r_bit - 1'b1;
                end
                S_MUL: begin
                    r_lin_prod <= 50'(r_gain) * 50'(r_root);
                    r_ang_prod <= ang_prod;
                    r_done <= (r_root < 34'(r_tol)) && (LW'(r_best) + 1'b1 == r_len);
                    r_state <= S_OUT1;
                end
                S_OUT1: begin
                    o_valid <= 1'b1;
                    o_linear_cmd <= lin_sat;
                    o_angular_cmd <= ang_sat;
                    o_path_done <= 1'b0;
                    o_last_result <= !r_done;
                    if (r_done) begin
                        r_len <= '0;
                        r_state <= S_OUT2;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT2: begin
                    o_valid <= 1'b1;
                    o_linear_cmd <= '0;
                    o_angular_cmd <= '0;
                    o_path_done <= 1'b1;
                    o_last_result <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/npf_ram.sv =====
// Generic single port RAM with registered read.
// Depends on nothing.
`default_nettype none
module npf_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and read one entry a cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== test/npf_checker.sv =====
// Checker for the nearest point path follower: watches item, result and register transfers.
// Predicts each tick's commands and compares them in order. Depends on npf_pkg.
`timescale 1ns / 1ps
module npf_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic               i_mode,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic               i_last_point,
    input  wire logic               i_pose_valid,
    input  wire logic signed [15:0] i_quat_x,
    input  wire logic signed [15:0] i_quat_y,
    input  wire logic signed [15:0] i_quat_z,
    input  wire logic signed [15:0] i_quat_w,
    input  wire logic               o_valid,
    input  wire logic [31:0]        o_linear_cmd,
    input  wire logic signed [23:0] o_angular_cmd,
    input  wire logic               o_path_done,
    input  wire logic               o_last_result,
    input  wire logic               i_cfg_valid,
    input  wire logic               o_cfg_ready,
    input  wire logic [npf_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    output int                      o_pending,
    output int                      o_fail_count
);
    import npf_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam int ROT_STEPS   = 16;

    typedef struct packed {
        logic [31:0]        lin;
        logic signed [23:0] ang;
        logic               done;
        logic               last;
    } cmd_t;

    // Rounded atan(2^-i), radians * 2^30
    localparam longint ROT_ANGLE [0:15] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
        131072, 65536, 32768};

    logic signed [31:0] way_x [STORE_DEPTH];
    logic signed [31:0] way_y [STORE_DEPTH];
    int                 way_count;
    logic               new_path_next;
    logic [15:0]        gain_q88;
    logic [31:0]        tol_q16;
    cmd_t               expected_cmds[$];
    int                 fails;

    assign o_fail_count = fails;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fails++;
    endtask

    // Vectoring rotation: angle of (x, y) in radians * 2^30
    function automatic longint vector_angle(input longint y_in, input longint x_in);
        longint x, y, z, t, sx, sy;
        int     i;
        x = x_in;
        y = y_in;
        z = 0;
        if (x == 0 && y == 0) return 0;
        // turn a left half-plane vector into the right one
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = longint'(HALF_PI_Q30);
            end else begin
                x = -y;
                y = t;
                z = -longint'(HALF_PI_Q30);
            end
        end
        for (i = 0; i < ROT_STEPS; i++) begin
            sx = x >>> i;
            sy = y >>> i;
            if (y > 0) begin
                x = x + sy;
                y = y - sx;
                z = z + ROT_ANGLE[i];
            end else begin
                x = x - sy;
                y = y + sx;
                z = z - ROT_ANGLE[i];
            end
        end
        return z;
    endfunction

    function automatic logic [67:0] range_sq(input longint dx, input longint dy);
        logic [67:0] ax, ay;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        return ax * ax + ay * ay;
    endfunction

    function automatic logic [67:0] floor_sqrt(input logic [67:0] s);
        logic [67:0] r, t;
        int          b;
        r = '0;
        for (b = 33; b >= 0; b--) begin
            t = r | (68'd1 << b);
            if (!(s < t * t)) r = t;
        end
        return r;
    endfunction

    // Compute the commands of one tick and queue them
    task automatic predict_tick();
        longint      rx, ry, qx, qy, qz, qw, dx, dy, heading, yaw, err, ang;
        logic [67:0] best_sq, d, range_m, lin;
        int          best, i;
        cmd_t        c;
        if (i_pose_valid) begin
            rx = i_pos_x;  ry = i_pos_y;
            qx = i_quat_x; qy = i_quat_y; qz = i_quat_z; qw = i_quat_w;
        end else begin
            rx = 0; ry = 0; qx = 0; qy = 0; qz = 0; qw = 16384;
        end
        best = 0;
        best_sq = range_sq(longint'(way_x[0]) - rx, longint'(way_y[0]) - ry);
        for (i = 1; i < way_count; i++) begin
            d = range_sq(longint'(way_x[i]) - rx, longint'(way_y[i]) - ry);
            if (d < best_sq) begin
                best_sq = d;
                best = i;
            end
        end
        dx = longint'(way_x[best]) - rx;
        dy = longint'(way_y[best]) - ry;
        heading = vector_angle(dy, dx);
        yaw = vector_angle(2 * (qw * qz + qx * qy), qw * qw + qx * qx - qy * qy - qz * qz);
        err = heading - yaw;
        if (err > longint'(PI_Q30)) err = err - longint'(TWO_PI_Q30);
        if (err < -longint'(PI_Q30)) err = err + longint'(TWO_PI_Q30);
        range_m = floor_sqrt(best_sq);
        lin = (range_m * gain_q88) >> 8;
        if (lin > 68'hFFFF_FFFF) lin = 68'hFFFF_FFFF;
        ang = (longint'(gain_q88) * err) >>> 25;
        if (ang > longint'(ANG_MAX)) ang = longint'(ANG_MAX);
        if (ang < -longint'(ANG_MAX)) ang = -longint'(ANG_MAX);
        c.lin  = lin[31:0];
        c.ang  = ang[23:0];
        c.done = 1'b0;
        c.last = 1'b1;
        // goal reached on the final point: command, then stop
        if (range_m < {36'd0, tol_q16} && best == way_count - 1) begin
            c.last = 1'b0;
            expected_cmds.push_back(c);
            c = '{lin: '0, ang: '0, done: 1'b1, last: 1'b1};
            way_count = 0;
        end
        expected_cmds.push_back(c);
    endtask

    always @(posedge i_clk) begin
        cmd_t want;
        if (!i_rst_n) begin
            way_count     = 0;
            new_path_next = 1'b1;
            gain_q88      = 16'd256;
            tol_q16       = 32'd3277;
            expected_cmds.delete();
        end else begin
            // compare a result before queueing anything new
            if (o_valid) begin
                if (expected_cmds.size() == 0) begin
                    report_mismatch("unexpected result, linear", o_linear_cmd, 0);
                end else begin
                    want = expected_cmds.pop_front();
                    if (o_linear_cmd !== want.lin)
                        report_mismatch("linear_cmd", o_linear_cmd, want.lin);
                    if (o_angular_cmd !== want.ang)
                        report_mismatch("angular_cmd", o_angular_cmd, want.ang);
                    if (o_path_done !== want.done)
                        report_mismatch("path_done", o_path_done, want.done);
                    if (o_last_result !== want.last)
                        report_mismatch("last_result", o_last_result, want.last);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_GAIN) gain_q88 = i_cfg_data[15:0];
                else if (i_cfg_index == CFG_TOL) tol_q16 = i_cfg_data;
            end
            if (start && !busy) begin
                if (!i_mode) begin
                    // append a point, drop it when the store is full
                    if (new_path_next) begin
                        way_count = 0;
                        new_path_next = 1'b0;
                    end
                    if (way_count < STORE_DEPTH) begin
                        way_x[way_count] = i_pos_x;
                        way_y[way_count] = i_pos_y;
                        way_count++;
                    end
                    if (i_last_point) new_path_next = 1'b1;
                end else if (way_count != 0) begin
                    predict_tick();
                end
            end
        end
        o_pending <= expected_cmds.size();
    end

    initial begin
        fails = 0;
        o_pending = 0;
    end
endmodule

// ===== test/tb_nearest_point_path_follower.sv =====
// Testbench top for the nearest point path follower: clock, reset, stimulus and verdict.
// Depends on npf_pkg, npf_checker and the block itself.
`timescale 1ns / 1ps
module tb_nearest_point_path_follower;
    import npf_pkg::*;

    localparam int RANDOM_ITEMS = 540;
    localparam int STALL_LIMIT  = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_mode;
    logic signed [31:0] i_pos_x;
    logic signed [31:0] i_pos_y;
    logic               i_last_point;
    logic               i_pose_valid;
    logic signed [15:0] i_quat_x;
    logic signed [15:0] i_quat_y;
    logic signed [15:0] i_quat_z;
    logic signed [15:0] i_quat_w;
    logic               o_valid;
    logic [31:0]        o_linear_cmd;
    logic signed [23:0] o_angular_cmd;
    logic               o_path_done;
    logic               o_last_result;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CfgIdxW-1:0] i_cfg_index;
    logic [31:0]        i_cfg_data;
    int                 pending;
    int                 fail_count;
    int                 quiet_cycles;
    int                 items_sent;
    logic signed [31:0] tail_x, tail_y;

    nearest_point_path_follower u_top (.*);

    npf_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_mode, .i_pos_x, .i_pos_y,
        .i_last_point, .i_pose_valid, .i_quat_x, .i_quat_y, .i_quat_z,
        .i_quat_w, .o_valid, .o_linear_cmd, .o_angular_cmd, .o_path_done,
        .o_last_result, .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_pending(pending), .o_fail_count(fail_count)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Coordinate: mostly a few metres, sometimes full range
    function automatic logic [31:0] pick_coord();
        if ($urandom_range(3) == 0) return $urandom;
        return $urandom_range(655360) - 327680;
    endfunction

    function automatic logic [15:0] pick_quat();
        return 16'($urandom_range(32768) - 16384);
    endfunction

    // Transfer one item, then idle for a random gap that is often zero
    task automatic send(input logic mode, input logic [31:0] px, input logic [31:0] py,
                        input logic lastp, input logic pvalid, input logic [15:0] qx,
                        input logic [15:0] qy, input logic [15:0] qz, input logic [15:0] qw);
        int gap;
        i_mode       <= mode;
        i_pos_x      <= px;
        i_pos_y      <= py;
        i_last_point <= lastp;
        i_pose_valid <= pvalid;
        i_quat_x     <= qx;
        i_quat_y     <= qy;
        i_quat_z     <= qz;
        i_quat_w     <= qw;
        start        <= 1'b1;
        do @(posedge i_clk); while (busy);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic load_point(input logic [31:0] px, input logic [31:0] py, input logic lastp);
        send(1'b0, px, py, lastp, 1'($urandom_range(1)), pick_quat(), pick_quat(), pick_quat(),
             pick_quat());
        tail_x = px;
        tail_y = py;
    endtask

    task automatic tick(input logic [31:0] px, input logic [31:0] py, input logic pvalid);
        send(1'b1, px, py, 1'($urandom_range(1)), pvalid, pick_quat(), pick_quat(), pick_quat(),
             pick_quat());
    endtask

    // Hold off until every command has arrived and the block is idle
    task automatic drain();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0 || busy);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int n, k, r;
        items_sent   = 0;
        quiet_cycles = 0;
        start        = 1'b0;
        i_mode       = 1'b0;
        i_pos_x      = '0;
        i_pos_y      = '0;
        i_last_point = 1'b0;
        i_pose_valid = 1'b0;
        i_quat_x     = '0;
        i_quat_y     = '0;
        i_quat_z     = '0;
        i_quat_w     = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_GAIN;
        i_cfg_data   = '0;
        i_rst_n      = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty path tick, field extremes, ties, goal cases
        tick(32'h1234, 32'h5678, 1'b1);
        load_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        load_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        load_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1,
             16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384);
        send(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1,
             -16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384);
        send(1'b1, 32'h0, 32'h0, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send(1'b1, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
        // equal distance on both sides: lowest index wins
        load_point(32'h0001_0000, 32'h0, 1'b0);
        load_point(-32'sh0001_0000, 32'h0, 1'b1);
        tick(32'h0, 32'h0, 1'b1);
        tick(32'h0, 32'h0, 1'b0);
        // robot on the last point: goal with zero distance
        tick(-32'sh0001_0000, 32'h0, 1'b1);
        // goal reached while a path is still loading, then keep loading
        load_point(32'h0002_0000, 32'h0003_0000, 1'b0);
        tick(32'h0002_0000, 32'h0003_0000, 1'b1);
        load_point(32'h0005_0000, 32'h0, 1'b0);
        load_point(32'h0006_0000, 32'h0, 1'b1);
        tick(32'h0005_0000, 32'h0, 1'b1);
        tick(32'h0006_0000, 32'h0, 1'b0);
        drain();

        // Fill the store past its depth, then tick over the full store
        for (k = 0; k < 1030; k++) load_point(pick_coord(), pick_coord(), k == 1029);
        tick(pick_coord(), pick_coord(), 1'b1);
        tick(32'h0, 32'h0, 1'b1);
        drain();
        items_sent = 0;

        // Random: paths with ticks, under several register settings
        for (n = 0; items_sent < RANDOM_ITEMS; n++) begin
            if (n % 12 == 0) begin
                drain();
                case ((n / 12) % 6)
                    0: begin write_reg(CFG_GAIN, 32'd0); write_reg(CFG_TOL, 32'hFFFF_FFFF); end
                    1: begin write_reg(CFG_GAIN, 32'hFFFF); write_reg(CFG_TOL, 32'd0); end
                    2: begin write_reg(CFG_GAIN, 32'd256); write_reg(CFG_TOL, 32'd3277); end
                    3: begin write_reg(CFG_GAIN, $urandom); write_reg(CFG_TOL, $urandom); end
                    default: begin
                        write_reg(CFG_GAIN, $urandom_range(2048));
                        write_reg(CFG_TOL, $urandom_range(400000));
                    end
                endcase
            end
            r = $urandom_range(9);
            if (r == 0) begin
                // noise: a lone item of either kind
                send(1'($urandom_range(1)), $urandom, $urandom, 1'($urandom_range(1)),
                     1'($urandom_range(1)), pick_quat(), pick_quat(), pick_quat(),
                     pick_quat());
            end else begin
                k = $urandom_range(8, 1);
                repeat (k) load_point(pick_coord(), pick_coord(), 1'b0);
                if (r != 1) load_point(pick_coord(), pick_coord(), 1'b1);
                repeat ($urandom_range(6, 1)) begin
                    case ($urandom_range(4))
                        0, 1: tick(tail_x, tail_y, 1'b1);
                        2: tick(tail_x + $urandom_range(8000) - 4000,
                                tail_y + $urandom_range(8000) - 4000, 1'b1);
                        3: tick(pick_coord(), pick_coord(), 1'b1);
                        default: tick(pick_coord(), pick_coord(), 1'b0);
                    endcase
                end
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
